### hdl/dlpd_pkg.sv
package dlpd_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int HEADER_MAX   = 19;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 13;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = LEN_W + 4;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = '0;

    localparam logic [BYTE_W-1:0] SEPARATOR = 8'h7C;
    localparam logic [BYTE_W-1:0] DIGIT_0   = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_9   = 8'h39;

    localparam logic [LEN_W-1:0] LEN_SAT       = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_BUFFER    = LEN_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(BUFFER_BYTES - 15);
    localparam logic [CNT_W-1:0] HEADER_LIMIT  = CNT_W'(HEADER_MAX);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CNT_W-1:0]  cnt_t;

endpackage

### hdl/dlpd_rx_if.sv
interface dlpd_rx_if;

    logic            valid;
    logic            ready;
    dlpd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

### hdl/dlpd_tx_if.sv
interface dlpd_tx_if;

    logic            valid;
    logic            ready;
    dlpd_pkg::byte_t body_byte;
    logic            byte_present;
    logic            packet_last;
    logic            frame_error;

    modport source (
        output valid,
        output body_byte,
        output byte_present,
        output packet_last,
        output frame_error,
        input  ready
    );
    modport sink (
        input  valid,
        input  body_byte,
        input  byte_present,
        input  packet_last,
        input  frame_error,
        output ready
    );

endinterface

### hdl/decimal_length_prefix_deframer.sv
// A result is registered in the output register in the cycle after its input transfer.
// One byte per cycle unless tx stalls; one output register parts the two channels.
// Header bytes, other than an error or an empty packet, give no result.
// Reset (rst_n low, asynchronous) returns to header parsing with no result pending
// and sets max_body_length to 4081.
module decimal_length_prefix_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    dlpd_rx_if.sink                           rx,
    dlpd_tx_if.source                         tx,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dlpd_pkg::ADDR_W-1:0]       paddr,
    input  logic [dlpd_pkg::DATA_W-1:0]       pwdata,
    output logic [dlpd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    dlpd_pkg::len_t  max_len_reg;
    logic            in_body_reg;
    logic            in_body_next;
    dlpd_pkg::len_t  acc_reg;
    dlpd_pkg::len_t  acc_next;
    logic            ended_reg;
    logic            ended_next;
    dlpd_pkg::cnt_t  count_reg;
    dlpd_pkg::cnt_t  count_next;
    dlpd_pkg::len_t  remain_reg;
    dlpd_pkg::len_t  remain_next;

    logic            tx_valid_reg;
    logic            tx_valid_next;
    dlpd_pkg::byte_t tx_byte_reg;
    logic            tx_present_reg;
    logic            tx_last_reg;
    logic            tx_error_reg;

    logic            emit;
    dlpd_pkg::byte_t emit_byte;
    logic            emit_present;
    logic            emit_last;
    logic            emit_error;

    logic                          rx_fire;
    logic                          cfg_write;
    logic                          cfg_hit;
    dlpd_pkg::byte_t               b;
    dlpd_pkg::len_t                limit;
    logic [dlpd_pkg::PROD_W-1:0]   product;
    logic                          is_digit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr == dlpd_pkg::ADDR_MAX_LEN);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? {{(dlpd_pkg::DATA_W - dlpd_pkg::LEN_W){1'b0}}, max_len_reg}
                               : '0;

    assign rx.ready = !tx_valid_reg || tx.ready;
    assign rx_fire  = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    assign limit    = (max_len_reg > dlpd_pkg::LEN_BUFFER) ? dlpd_pkg::LEN_BUFFER : max_len_reg;
    assign is_digit = (b >= dlpd_pkg::DIGIT_0) && (b <= dlpd_pkg::DIGIT_9);
    assign product  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + dlpd_pkg::PROD_W'(b - dlpd_pkg::DIGIT_0);

    always_comb
    begin
        in_body_next = in_body_reg;
        acc_next     = acc_reg;
        ended_next   = ended_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        emit_byte    = '0;
        emit_present = 1'b0;
        emit_last    = 1'b0;
        emit_error   = 1'b0;

        if (in_body_reg)
        begin
            emit         = 1'b1;
            emit_byte    = b;
            emit_present = 1'b1;
            if (remain_reg <= dlpd_pkg::LEN_W'(1))
            begin
                emit_last    = 1'b1;
                remain_next  = '0;
                in_body_next = 1'b0;
            end
            else
            begin
                remain_next = remain_reg - dlpd_pkg::LEN_W'(1);
            end
        end
        else if (b == dlpd_pkg::SEPARATOR)
        begin
            acc_next   = '0;
            ended_next = 1'b0;
            count_next = '0;
            if (acc_reg > limit)
            begin
                emit       = 1'b1;
                emit_error = 1'b1;
            end
            else if (acc_reg == '0)
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
            end
            else
            begin
                in_body_next = 1'b1;
                remain_next  = acc_reg;
            end
        end
        else if (count_reg >= dlpd_pkg::HEADER_LIMIT)
        begin
            acc_next   = '0;
            ended_next = 1'b0;
            count_next = '0;
            emit       = 1'b1;
            emit_error = 1'b1;
        end
        else
        begin
            count_next = count_reg + dlpd_pkg::CNT_W'(1);
            if (!ended_reg && is_digit)
            begin
                if (product > dlpd_pkg::PROD_W'(dlpd_pkg::LEN_SAT))
                begin
                    acc_next = dlpd_pkg::LEN_SAT;
                end
                else
                begin
                    acc_next = product[dlpd_pkg::LEN_W-1:0];
                end
            end
            else
            begin
                ended_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (rx_fire)
        begin
            tx_valid_next = emit;
        end
        else if (tx.ready)
        begin
            tx_valid_next = 1'b0;
        end
        else
        begin
            tx_valid_next = tx_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= dlpd_pkg::MAX_LEN_RESET;
            in_body_reg  <= 1'b0;
            acc_reg      <= '0;
            ended_reg    <= 1'b0;
            count_reg    <= '0;
            remain_reg   <= '0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_len_reg <= pwdata[dlpd_pkg::LEN_W-1:0];
            end
            if (rx_fire)
            begin
                in_body_reg <= in_body_next;
                acc_reg     <= acc_next;
                ended_reg   <= ended_next;
                count_reg   <= count_next;
                remain_reg  <= remain_next;
            end
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && emit)
        begin
            tx_byte_reg    <= emit_byte;
            tx_present_reg <= emit_present;
            tx_last_reg    <= emit_last;
            tx_error_reg   <= emit_error;
        end
    end

    assign tx.valid        = tx_valid_reg;
    assign tx.body_byte    = tx_byte_reg;
    assign tx.byte_present = tx_present_reg;
    assign tx.packet_last  = tx_last_reg;
    assign tx.frame_error  = tx_error_reg;

    // A body in progress always has at least one byte left to forward.
    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> (remain_reg != '0))
        else $error("body active with no bytes remaining");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dlpd_pkg::HEADER_LIMIT)
        else $error("header count beyond its limit");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid_reg |-> !(tx_error_reg && (tx_present_reg || tx_last_reg)))
        else $error("error result carries data or a last mark");

    a_body_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && in_body_reg && (remain_reg > dlpd_pkg::LEN_W'(1))) |=> in_body_reg)
        else $error("body ended early");

endmodule
